FILE: rtl/core/rar_pkg.sv
// shared types, widths and helpers for the rational arithmetic reducer
package rar_pkg;

  localparam int OPERAND_W = 16;
  localparam int MAG_W     = OPERAND_W;
  localparam int PROD_W    = 2 * OPERAND_W;
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 31;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0]                  func;
    logic signed [OPERAND_W-1:0] a_num;
    logic signed [OPERAND_W-1:0] a_den;
    logic signed [OPERAND_W-1:0] b_num;
    logic signed [OPERAND_W-1:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic signed [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0]        res_den;
    logic                        div_zero;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_RED,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    RED_IDLE,
    RED_GCD,
    RED_DIVN,
    RED_DIVD
  } red_state_e;

  // magnitude of a two's complement operand, most negative value included
  function automatic logic [MAG_W-1:0] mag_of(input logic [OPERAND_W-1:0] v);
    logic [OPERAND_W-1:0] neg_v;
    neg_v = ~v + 1'b1;
    return v[OPERAND_W-1] ? neg_v : v;
  endfunction

endpackage

FILE: rtl/core/rar_reduce.sv
// binary gcd and restoring divider sharing one subtractor
module rar_reduce #(
  parameter int NW = rar_pkg::PROD_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] num_o,
  output logic [NW-1:0] den_o
);

  localparam int KW = $clog2(NW);
  localparam int CW = $clog2(NW);

  rar_pkg::red_state_e state_q, state_d;

  logic [NW-1:0] u_q, u_d;
  logic [NW-1:0] v_q, v_d;
  logic [KW-1:0] k_q, k_d;
  logic [NW-1:0] g_q, g_d;
  logic [NW-1:0] r_q, r_d;
  logic [NW-1:0] q_q, q_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] num_hold_q, num_hold_d;
  logic [NW-1:0] den_hold_q, den_hold_d;
  logic [NW-1:0] num_res_q, num_res_d;
  logic [NW-1:0] den_res_q, den_res_d;
  logic          done_q, done_d;

  // the one subtractor: u - v during gcd, partial remainder - g during divide
  logic [NW:0] sub_a, sub_b, diff;
  logic        borrow;
  logic        gcd_end;
  logic [NW-1:0] q_next;

  always_comb begin
    if (state_q == rar_pkg::RED_GCD) begin
      sub_a = {1'b0, u_q};
      sub_b = {1'b0, v_q};
    end else begin
      sub_a = {r_q, q_q[NW-1]};
      sub_b = {1'b0, g_q};
    end
  end

  assign diff    = sub_a - sub_b;
  assign borrow  = diff[NW];
  assign gcd_end = (u_q == '0) || (v_q == '0);
  assign q_next  = {q_q[NW-2:0], ~borrow};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rar_pkg::RED_IDLE: begin
        if (start_i) state_d = rar_pkg::RED_GCD;
      end
      rar_pkg::RED_GCD: begin
        if (gcd_end) state_d = rar_pkg::RED_DIVN;
      end
      rar_pkg::RED_DIVN: begin
        if (cnt_q == '0) state_d = rar_pkg::RED_DIVD;
      end
      rar_pkg::RED_DIVD: begin
        if (cnt_q == '0) state_d = rar_pkg::RED_IDLE;
      end
      default: state_d = rar_pkg::RED_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    u_d        = u_q;
    v_d        = v_q;
    k_d        = k_q;
    g_d        = g_q;
    r_d        = r_q;
    q_d        = q_q;
    cnt_d      = cnt_q;
    num_hold_d = num_hold_q;
    den_hold_d = den_hold_q;
    num_res_d  = num_res_q;
    den_res_d  = den_res_q;
    done_d     = 1'b0;
    case (state_q)
      rar_pkg::RED_IDLE: begin
        if (start_i) begin
          u_d        = num_i;
          v_d        = den_i;
          k_d        = '0;
          num_hold_d = num_i;
          den_hold_d = den_i;
        end
      end
      rar_pkg::RED_GCD: begin
        if (gcd_end) begin
          g_d   = (u_q | v_q) << k_q;
          r_d   = '0;
          q_d   = num_hold_q;
          cnt_d = CW'(NW - 1);
        end else if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (borrow) begin
          // both odd, u below v: swap so the next step subtracts downward
          u_d = v_q;
          v_d = u_q;
        end else begin
          u_d = diff[NW-1:0];
        end
      end
      rar_pkg::RED_DIVN, rar_pkg::RED_DIVD: begin
        r_d   = borrow ? sub_a[NW-1:0] : diff[NW-1:0];
        q_d   = q_next;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (state_q == rar_pkg::RED_DIVN) begin
            num_res_d = q_next;
            r_d       = '0;
            q_d       = den_hold_q;
            cnt_d     = CW'(NW - 1);
          end else begin
            den_res_d = q_next;
            done_d    = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rar_pkg::RED_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q        <= u_d;
    v_q        <= v_d;
    k_q        <= k_d;
    g_q        <= g_d;
    r_q        <= r_d;
    q_q        <= q_d;
    num_hold_q <= num_hold_d;
    den_hold_q <= den_hold_d;
    num_res_q  <= num_res_d;
    den_res_q  <= den_res_d;
  end

  assign done_o = done_q;
  assign num_o  = num_res_q;
  assign den_o  = den_res_q;

endmodule

FILE: rtl/core/rational_arithmetic_reduce.sv
// sequence: the multiply steps, the sum step, a data-dependent binary gcd loop, then
//   the numerator and denominator divisions and the output register; the gcd loop does
//   one shift, swap or subtract per pass, plus a final pass to finish;
//   0/1 and error words skip the gcd loop and the divisions
// throughput: one word in flight; in_ready_o is high only when the sequencer is idle,
//   so the next word can be taken in the cycle after the result register loads
// reset: rst_ni asynchronous active low clears the sequencer and the output valid
module rational_arithmetic_reduce (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rar_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rar_pkg::out_word_t out_word_o
);

  localparam int OW        = rar_pkg::OPERAND_W;
  localparam int MW        = rar_pkg::MAG_W;
  localparam int PW        = rar_pkg::PROD_W;
  localparam int NUM_EXT_W = (PW > rar_pkg::RES_NUM_W) ? PW : rar_pkg::RES_NUM_W;
  localparam int DEN_EXT_W = (PW > rar_pkg::RES_DEN_W) ? PW : rar_pkg::RES_DEN_W;

  rar_pkg::state_e state_q, state_d;

  // captured operands: magnitudes and raw sign bits
  rar_pkg::func_e func_q;
  logic [MW-1:0]  an_q, ad_q, bn_q, bd_q;
  logic           s_an_q, s_ad_q, s_bn_q, s_bd_q;
  logic           err_q;
  logic [1:0]     cnt_q, cnt_d;

  // products from the shared multiplier
  logic [PW-1:0]  p0_q, p1_q, p2_q;

  // reduced magnitudes and sign of the result
  logic [PW-1:0]  res_nm_q, res_dm_q;
  logic           neg_q;

  logic               out_valid_q, out_valid_d;
  rar_pkg::out_word_t out_word_q;

  logic in_fire;
  logic out_load;
  logic red_start;
  logic red_done;
  logic [PW-1:0] red_nm, red_dm;

  assign in_fire = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // shared multiplier: one product a cycle, operands picked by step and operation
  // ---------------------------------------------------------------------------
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod;

  always_comb begin
    case (cnt_q)
      2'd0: begin
        mul_a = an_q;
        mul_b = (func_q == rar_pkg::FUNC_MUL) ? bn_q : bd_q;
      end
      2'd1: begin
        mul_a = bn_q;
        mul_b = ad_q;
      end
      default: begin
        mul_a = ad_q;
        mul_b = (func_q == rar_pkg::FUNC_DIV) ? bn_q : bd_q;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // ---------------------------------------------------------------------------
  // numerator in sign-magnitude form; a zero product may carry a stray sign,
  // the larger-magnitude rule below makes that harmless
  // ---------------------------------------------------------------------------
  logic          s0, s1, s_den;
  logic [PW-1:0] num_mag;
  logic          num_neg;
  logic          num_zero;

  always_comb begin
    s0    = (func_q == rar_pkg::FUNC_MUL) ? (s_an_q ^ s_bn_q) : (s_an_q ^ s_bd_q);
    s1    = s_bn_q ^ s_ad_q ^ (func_q == rar_pkg::FUNC_SUB);
    s_den = (func_q == rar_pkg::FUNC_DIV) ? (s_ad_q ^ s_bn_q) : (s_ad_q ^ s_bd_q);
    if (func_q == rar_pkg::FUNC_MUL || func_q == rar_pkg::FUNC_DIV) begin
      num_mag = p0_q;
      num_neg = s0;
    end else if (s0 == s1) begin
      num_mag = p0_q + p1_q;
      num_neg = s0;
    end else if (p0_q >= p1_q) begin
      num_mag = p0_q - p1_q;
      num_neg = s0;
    end else begin
      num_mag = p1_q - p0_q;
      num_neg = s1;
    end
    num_zero = (num_mag == '0);
  end

  // ---------------------------------------------------------------------------
  // gcd reduction and the two exact divisions
  // ---------------------------------------------------------------------------
  rar_reduce #(
    .NW (PW)
  ) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (red_start),
    .num_i   (num_mag),
    .den_i   (p2_q),
    .done_o  (red_done),
    .num_o   (red_nm),
    .den_o   (red_dm)
  );

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      rar_pkg::ST_IDLE: begin
        if (in_fire) state_d = rar_pkg::ST_MUL;
      end
      rar_pkg::ST_MUL: begin
        if (cnt_q == 2'd2) state_d = rar_pkg::ST_SUM;
      end
      rar_pkg::ST_SUM: begin
        state_d = (err_q || num_zero) ? rar_pkg::ST_DONE : rar_pkg::ST_RED;
      end
      rar_pkg::ST_RED: begin
        if (red_done) state_d = rar_pkg::ST_DONE;
      end
      rar_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = rar_pkg::ST_IDLE;
      end
      default: state_d = rar_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ready_o  = (state_q == rar_pkg::ST_IDLE);
    red_start   = (state_q == rar_pkg::ST_SUM) && !err_q && !num_zero;
    out_load    = (state_q == rar_pkg::ST_DONE) && (!out_valid_q || out_ready_i);
    cnt_d       = (state_q == rar_pkg::ST_MUL) ? cnt_q + 2'd1 : 2'd0;
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // ---------------------------------------------------------------------------
  // output word formatting: sign onto the numerator, low bits kept
  // ---------------------------------------------------------------------------
  logic [NUM_EXT_W-1:0] num_ext, num_sgn;
  logic [DEN_EXT_W-1:0] den_ext;
  rar_pkg::out_word_t   fmt_word;

  always_comb begin
    num_ext           = NUM_EXT_W'(res_nm_q);
    num_sgn           = neg_q ? (~num_ext + 1'b1) : num_ext;
    den_ext           = DEN_EXT_W'(res_dm_q);
    fmt_word.res_num  = num_sgn[rar_pkg::RES_NUM_W-1:0];
    fmt_word.res_den  = den_ext[rar_pkg::RES_DEN_W-1:0];
    fmt_word.div_zero = err_q;
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rar_pkg::ST_IDLE;
      cnt_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= rar_pkg::func_e'(in_word_i.func);
      an_q   <= rar_pkg::mag_of(in_word_i.a_num);
      ad_q   <= rar_pkg::mag_of(in_word_i.a_den);
      bn_q   <= rar_pkg::mag_of(in_word_i.b_num);
      bd_q   <= rar_pkg::mag_of(in_word_i.b_den);
      s_an_q <= in_word_i.a_num[OW-1];
      s_ad_q <= in_word_i.a_den[OW-1];
      s_bn_q <= in_word_i.b_num[OW-1];
      s_bd_q <= in_word_i.b_den[OW-1];
      // zero denominator in, or divide by a zero fraction
      err_q  <= (in_word_i.a_den == '0) || (in_word_i.b_den == '0) ||
                ((rar_pkg::func_e'(in_word_i.func) == rar_pkg::FUNC_DIV) &&
                 (in_word_i.b_num == '0));
    end
    if (state_q == rar_pkg::ST_MUL) begin
      case (cnt_q)
        2'd0:    p0_q <= prod;
        2'd1:    p1_q <= prod;
        default: p2_q <= prod;
      endcase
    end
    if (state_q == rar_pkg::ST_SUM) begin
      res_nm_q <= '0;
      res_dm_q <= PW'(1);
      // sign only matters when the reducer runs
      neg_q    <= red_start ? (num_neg ^ s_den) : 1'b0;
    end
    if (state_q == rar_pkg::ST_RED && red_done) begin
      res_nm_q <= red_nm;
      res_dm_q <= red_dm;
    end
    if (out_load) begin
      out_word_q <= fmt_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: rtl/core/rar_checker.sv
// port-level checks for the rational arithmetic reducer, bound to the top level
module rar_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input rar_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input rar_pkg::out_word_t out_word_o
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  // one word at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("accepted a word while busy");

  // error words are always 0/1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.div_zero) |->
      (out_word_o.res_num == '0 && out_word_o.res_den == 1))
    else $error("error word is not 0/1");

  // denominator never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.res_den != '0))
    else $error("zero denominator delivered");

  // a zero numerator is reduced to 0/1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.res_num == '0) |-> (out_word_o.res_den == 1))
    else $error("zero numerator not reduced");

  // stalled output holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("output word changed while stalled");

endmodule

bind rational_arithmetic_reduce rar_checker u_rar_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
